>>> rtl/wbr_pkg.sv
// types, codes and constants shared by the windowed block receiver
package wbr_pkg;

	localparam int unsigned BLK_W = 16;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned OPC_W = 8;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [BLK_W-1:0] FULL_BLOCK_BYTES = 16'd512;
	localparam logic [OPC_W-1:0] DATA_OPCODE = 8'd3;
	localparam logic [BLK_W-1:0] TICKS_MAX = 16'hFFFF;

	localparam logic [BLK_W-1:0] WINDOW_SIZE_RST = 16'd8;
	localparam logic [BLK_W-1:0] HOLDOFF_RST = 16'd1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_HOLDOFF = 8'd1;

	// phase codes as reported on the result word
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_RECV = 2'd2;
	localparam logic [1:0] PH_FINAL = 2'd3;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_PACKET = 2'd1,
		ACT_TIMEOUT = 2'd2,
		ACT_TICK = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WAIT = 4'b0010,
		ST_RECV = 4'b0100,
		ST_FINAL = 4'b1000
	} phase_st_t;

	typedef struct packed {
		action_t action;
		logic [OPC_W-1:0] packet_opcode;
		logic [BLK_W-1:0] blk_num;
		logic [LEN_W-1:0] payload_length;
	} evt_t;

	typedef struct packed {
		logic ack_send;
		logic [BLK_W-1:0] ack_block;
		logic write_block;
		logic [1:0] phase;
		logic transfer_done;
	} res_t;

	typedef struct packed {
		phase_st_t st;
		logic [BLK_W-1:0] expected_block;
		logic [BLK_W-1:0] window_left;
		logic [BLK_W-1:0] last_ack_block;
		logic last_ack_known;
		logic [BLK_W-1:0] ticks_since_ack;
	} wbr_state_t;

	typedef struct packed {
		logic [BLK_W-1:0] window_size;
		logic [BLK_W-1:0] ack_holdoff_ticks;
	} wbr_cfg_t;

	function automatic logic [1:0] phase_code(phase_st_t st);
		logic [1:0] code;
		unique case (st)
			ST_IDLE: code = PH_IDLE;
			ST_WAIT: code = PH_WAIT;
			ST_RECV: code = PH_RECV;
			ST_FINAL: code = PH_FINAL;
			default: code = PH_IDLE;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/wbr_if.sv
// valid/ready channel interfaces for events, results and register writes
interface wbr_evt_if;
	logic valid;
	logic ready;
	wbr_pkg::evt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wbr_res_if;
	logic valid;
	logic ready;
	wbr_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wbr_cfg_if;
	logic valid;
	logic ready;
	logic [wbr_pkg::CFG_IDX_W-1:0] reg_index;
	logic [wbr_pkg::BLK_W-1:0] wr_data;
	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> rtl/windowed_block_receiver.sv
// windowed block receiver top level: event register, state, result register
// Usage: events (start, packet, receive timeout, tick) enter on the evt
// channel, one word per event, accepted when valid and ready are high at a
// rising edge of clk. Each event yields exactly one result word on the res
// channel: ack request and block number, write strobe for the payload, the
// phase after the event and the transfer-done flag.
// The cfg channel writes window_size (index 0) and ack_holdoff_ticks
// (index 1); it is always ready and other indexes are dropped. Write only
// while no event is in flight.
// An accepted event is registered in the event register, evaluated against
// the protocol state, and its result word is registered in the result
// register, from which it is valid on res. Throughput: one event per cycle
// while res is not stalled, set by the single state update per cycle that each event needs.
// A stalled res channel holds its word; one further event is held in the
// event register, after which evt.ready drops until the result is taken.
// arst_n clears both valid flags, puts the block in idle with all counters
// at zero and loads window_size 8 and ack_holdoff_ticks 1000.
module windowed_block_receiver (
	input logic clk,
	input logic arst_n,
	wbr_evt_if.sink evt,
	wbr_res_if.source res,
	wbr_cfg_if.sink cfg
);
	import wbr_pkg::*;

	logic evt_fire;
	logic adv;
	logic s1_valid_q;
	evt_t item_s1;
	wbr_state_t state_q;
	wbr_state_t state_nxt;
	wbr_cfg_t cfg_q;
	res_t res_nxt;
	res_t res_q;
	logic res_valid_q;

	// event stage moves on when the result register is free or being emptied
	assign adv = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || adv;
	assign evt_fire = evt.valid && evt.ready;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt_fire) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			item_s1 <= evt.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size <= WINDOW_SIZE_RST;
			cfg_q.ack_holdoff_ticks <= HOLDOFF_RST;
		end else if (cfg.valid) begin
			if (cfg.reg_index == REG_WINDOW_SIZE) begin
				cfg_q.window_size <= cfg.wr_data;
			end
			if (cfg.reg_index == REG_ACK_HOLDOFF) begin
				cfg_q.ack_holdoff_ticks <= cfg.wr_data;
			end
		end
	end

	wbr_core u_core (
		.item (item_s1),
		.cur (state_q),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.result (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.st <= ST_IDLE;
			state_q.expected_block <= '0;
			state_q.window_left <= '0;
			state_q.last_ack_block <= '0;
			state_q.last_ack_known <= 1'b0;
			state_q.ticks_since_ack <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	// an accepted in-order block moves the expected block number on by one
	a_write_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.write_block) |=>
		(state_q.expected_block == $past(state_q.expected_block) + 16'd1))
		else $error("expected block did not advance after a written block");

	// a result word without an ack carries block zero
	a_no_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_q.ack_send || (res_q.ack_block == '0)))
		else $error("ack block set without ack request");

	// start reloads the window and enters the wait phase
	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (item_s1.action == ACT_START)) |=>
		((state_q.st == ST_WAIT) && (state_q.window_left == $past(cfg_q.window_size))))
		else $error("start did not reload the window");

	// with the event register full and the result stalled, nothing more enters
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && res_valid_q && !res.ready) |-> !evt.ready)
		else $error("event accepted while both stages are full");

	// done is reported only together with the return to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.transfer_done) |=> (state_q.st == ST_IDLE))
		else $error("transfer done without return to idle");

endmodule

>>> rtl/wbr_core.sv
// next-state and result logic for one event of the block receiver
module wbr_core (
	input wbr_pkg::evt_t item,
	input wbr_pkg::wbr_state_t cur,
	input wbr_pkg::wbr_cfg_t cfg,
	output wbr_pkg::wbr_state_t nxt,
	output wbr_pkg::res_t result
);
	import wbr_pkg::*;

	logic [BLK_W-1:0] exp_inc;
	logic [BLK_W-1:0] win_dec;
	logic short_blk;
	logic dup_ok;

	assign exp_inc = cur.expected_block + 16'd1;
	assign win_dec = cur.window_left - 16'd1;
	assign short_blk = {{(BLK_W-LEN_W){1'b0}}, item.payload_length} < FULL_BLOCK_BYTES;
	// an out-of-order block is answered unless the same ack went out within the holdoff
	assign dup_ok = !cur.last_ack_known || (cur.last_ack_block != cur.expected_block) ||
		(cur.ticks_since_ack >= cfg.ack_holdoff_ticks);

	always_comb begin
		nxt = cur;
		result = '0;
		unique case (item.action)
			ACT_START: begin
				nxt.st = ST_WAIT;
				nxt.expected_block = '0;
				nxt.window_left = cfg.window_size;
				nxt.last_ack_known = 1'b0;
				nxt.last_ack_block = '0;
				nxt.ticks_since_ack = '0;
				result.ack_send = 1'b1;
			end
			ACT_TICK: begin
				if (cur.ticks_since_ack != TICKS_MAX) begin
					nxt.ticks_since_ack = cur.ticks_since_ack + 16'd1;
				end
			end
			ACT_TIMEOUT: begin
				unique case (cur.st)
					ST_WAIT: begin
						result.ack_send = 1'b1;
						result.ack_block = cur.expected_block;
					end
					ST_RECV: begin
						result.ack_send = 1'b1;
						result.ack_block = cur.expected_block;
						nxt.window_left = cfg.window_size;
					end
					ST_FINAL: begin
						result.transfer_done = 1'b1;
						nxt.st = ST_IDLE;
					end
					default: begin
					end
				endcase
			end
			ACT_PACKET: begin
				if (cur.st == ST_FINAL) begin
					result.ack_send = 1'b1;
					result.ack_block = cur.expected_block;
				end else if (cur.st != ST_IDLE) begin
					nxt.st = ST_RECV;
					if (item.packet_opcode == DATA_OPCODE) begin
						if (item.blk_num == cur.expected_block) begin
							result.write_block = 1'b1;
							nxt.expected_block = exp_inc;
							nxt.window_left = win_dec;
							if (short_blk) begin
								nxt.st = ST_FINAL;
								result.ack_send = 1'b1;
								result.ack_block = exp_inc;
							end else if (win_dec == '0) begin
								result.ack_send = 1'b1;
								result.ack_block = exp_inc;
								nxt.window_left = cfg.window_size;
							end
						end else if (dup_ok) begin
							result.ack_send = 1'b1;
							result.ack_block = cur.expected_block;
							nxt.window_left = cfg.window_size;
							nxt.ticks_since_ack = '0;
							nxt.last_ack_block = cur.expected_block;
							nxt.last_ack_known = 1'b1;
						end
					end
				end
			end
		endcase
		result.phase = phase_code(nxt.st);
	end

endmodule
